### rtl/core/periodic_timer_scheduler_unit_defines.svh
// Assertion macros used by the timer scheduler checker.
`ifndef PERIODIC_TIMER_SCHEDULER_UNIT_DEFINES_SVH
`define PERIODIC_TIMER_SCHEDULER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTS_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PTS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/pts_pkg.sv
// Types, codes and constants shared by the timer scheduler modules.
package pts_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int TIME_WIDTH_DEF = 32;
    localparam int FIRE_LIMIT     = 16;
    localparam int FIRE_CNT_W     = $clog2(FIRE_LIMIT + 1);

    localparam int ID_W       = 8;
    localparam int DELAY_W    = 31;
    localparam int INTERVAL_W = 31;
    localparam int REPEAT_W   = 16;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_ADD  = 1'b1;

    typedef enum logic [1:0] {
        KIND_FIRED    = 2'd0,
        KIND_ADDED    = 2'd1,
        KIND_REJECTED = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_SCAN,
        ST_SCAN,
        ST_DECIDE,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic                  command;
        logic [ID_W-1:0]       timer_id;
        logic [DELAY_W-1:0]    first_delay;
        logic [INTERVAL_W-1:0] interval;
        logic [REPEAT_W-1:0]   repeat_count;
    } in_item_t;

    typedef struct packed {
        kind_t               kind;
        logic [ID_W-1:0]     timer_id_res;
        logic [REPEAT_W-1:0] repeats_left;
        logic                last;
    } out_item_t;

endpackage

### rtl/core/periodic_timer_scheduler_unit.sv
// Top level of the periodic timer scheduler: slot table, time counter and fire sequencer.
//
// Usage: items arrive on the s_ channel (valid/ready). An item with command
// set adds a timer; it gives exactly one result item (accepted or rejected,
// last set). An item with command clear is one tick: the time counter moves
// on by one and every due timer fires, earliest deadline first and lowest
// slot first on ties, one result item per fire, at most 16 per tick, with
// last set on the final one. A tick with nothing due gives no result.
// Results leave on the m_ channel (valid/ready) from an output register.
// Timing: the slot table sits in one RAM that is read one slot per cycle.
// An add walks the occupancy bits one slot at a time up to the first free
// one, that one included, then hands the result to the output register.
// A tick runs one table scan per fire plus a final scan that finds nothing
// due (none after the sixteenth fire). A new item is taken only once the
// previous one has delivered its last result to the output register.
// Reset empties the table and clears the time to zero; no clearing pass is
// needed since occupancy lives in flip-flops. When the receiver stalls, the
// scan still runs; a fire waits only when a finished result has nowhere to go.
module periodic_timer_scheduler_unit
    import pts_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF,
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W = $clog2(NUM_TIMERS + 1);

    // One table entry as it sits in the RAM.
    typedef struct packed {
        logic [ID_W-1:0]       id;
        logic [TIME_WIDTH-1:0] deadline;
        logic [INTERVAL_W-1:0] interval;
        logic [REPEAT_W-1:0]   repeats;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

    // Control state.
    state_t                  state_reg, state_next;
    logic [TIME_WIDTH-1:0]   time_reg, time_next;
    logic [NUM_TIMERS-1:0]   valid_reg, valid_next;
    logic [CNT_W-1:0]        scan_cnt_reg, scan_cnt_next;
    logic                    eval_en_reg, eval_en_next;
    logic                    best_found_reg, best_found_next;
    logic [FIRE_CNT_W-1:0]   fire_cnt_reg, fire_cnt_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic                    m_valid_reg, m_valid_next;

    // Payload state.
    in_item_t                in_reg, in_next;
    logic [IDX_W-1:0]        eval_idx_reg, eval_idx_next;
    logic [IDX_W-1:0]        best_idx_reg, best_idx_next;
    logic [TIME_WIDTH-1:0]   best_late_reg, best_late_next;
    slot_entry_t             best_entry_reg, best_entry_next;
    out_item_t               pend_item_reg, pend_item_next;
    out_item_t               m_item_reg, m_item_next;

    // RAM port signals.
    logic                    ram_wr_en;
    logic [IDX_W-1:0]        ram_wr_addr;
    slot_entry_t             ram_wr_entry;
    logic                    ram_rd_en;
    logic [IDX_W-1:0]        ram_rd_addr;
    logic [ENTRY_W-1:0]      ram_rd_data;

    // Datapath helpers.
    slot_entry_t             rd_entry;
    logic [TIME_WIDTH-1:0]   rd_late;
    logic                    rd_due;
    logic                    out_free;
    logic                    push_en;
    out_item_t               push_item;
    slot_entry_t             fire_entry;
    logic                    fire_removes;
    logic [IDX_W-1:0]        add_idx;
    logic [INTERVAL_W-1:0]   add_interval;

    pts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_TIMERS),
        .ADDR_W(IDX_W)
    ) u_slot_ram (
        .clk    (aclk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_entry),
        .rd_en  (ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    // Lateness of the slot whose data just came out of the RAM. A timer is
    // due when the wrapped difference reads as non-negative.
    assign rd_entry = slot_entry_t'(ram_rd_data);
    assign rd_late  = time_reg - rd_entry.deadline;
    assign rd_due   = valid_reg[eval_idx_reg] && !rd_late[TIME_WIDTH-1];

    // The output register can take a new item this cycle.
    assign out_free = !m_valid_reg || m_ready;

    // Entry after firing the chosen timer: deadline moves on by the interval,
    // a nonzero repeat count counts down and the slot frees when it hits zero.
    always_comb begin
        fire_entry          = best_entry_reg;
        fire_entry.deadline = best_entry_reg.deadline + TIME_WIDTH'(best_entry_reg.interval);
        fire_removes        = 1'b0;
        if (best_entry_reg.repeats != '0) begin
            fire_entry.repeats = best_entry_reg.repeats - REPEAT_W'(1);
            fire_removes       = (best_entry_reg.repeats == REPEAT_W'(1));
        end
    end

    // An interval of zero is loaded as one.
    assign add_interval = (in_reg.interval == '0) ? INTERVAL_W'(1) : in_reg.interval;
    assign add_idx      = scan_cnt_reg[IDX_W-1:0];

    always_comb begin
        state_next      = state_reg;
        time_next       = time_reg;
        valid_next      = valid_reg;
        scan_cnt_next   = scan_cnt_reg;
        eval_en_next    = 1'b0;
        eval_idx_next   = scan_cnt_reg[IDX_W-1:0];
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_late_next  = best_late_reg;
        best_entry_next = best_entry_reg;
        fire_cnt_next   = fire_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_item_next  = pend_item_reg;
        in_next         = in_reg;
        push_en         = 1'b0;
        push_item       = pend_item_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = best_idx_reg;
        ram_wr_entry    = fire_entry;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = scan_cnt_reg[IDX_W-1:0];
        s_ready         = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    in_next         = s_item;
                    scan_cnt_next   = '0;
                    best_found_next = 1'b0;
                    fire_cnt_next   = '0;
                    if (s_item.command == CMD_ADD) begin
                        state_next = ST_ADD_SCAN;
                    end else begin
                        time_next  = time_reg + TIME_WIDTH'(1);
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_ADD_SCAN: begin
                // Walk the occupancy bits for the lowest free slot.
                if (!valid_reg[add_idx]) begin
                    ram_wr_en               = 1'b1;
                    ram_wr_addr             = add_idx;
                    ram_wr_entry.id         = in_reg.timer_id;
                    ram_wr_entry.deadline   = time_reg + TIME_WIDTH'(in_reg.first_delay);
                    ram_wr_entry.interval   = add_interval;
                    ram_wr_entry.repeats    = in_reg.repeat_count;
                    valid_next[add_idx]     = 1'b1;
                    pend_item_next.kind         = KIND_ADDED;
                    pend_item_next.timer_id_res = in_reg.timer_id;
                    pend_item_next.repeats_left = in_reg.repeat_count;
                    pend_item_next.last         = 1'b1;
                    pend_valid_next = 1'b1;
                    state_next      = ST_FLUSH;
                end else if (scan_cnt_reg == CNT_W'(NUM_TIMERS - 1)) begin
                    pend_item_next.kind         = KIND_REJECTED;
                    pend_item_next.timer_id_res = in_reg.timer_id;
                    pend_item_next.repeats_left = '0;
                    pend_item_next.last         = 1'b1;
                    pend_valid_next = 1'b1;
                    state_next      = ST_FLUSH;
                end else begin
                    scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                end
            end

            ST_SCAN: begin
                // Issue one read per cycle; evaluate the data in the next cycle.
                if (scan_cnt_reg < CNT_W'(NUM_TIMERS)) begin
                    ram_rd_en     = 1'b1;
                    eval_en_next  = 1'b1;
                    scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                end
                if (eval_en_reg) begin
                    // Strictly later wins, so ties stay with the lower slot.
                    if (rd_due && (!best_found_reg || rd_late > best_late_reg)) begin
                        best_found_next = 1'b1;
                        best_idx_next   = eval_idx_reg;
                        best_late_next  = rd_late;
                        best_entry_next = rd_entry;
                    end
                end else if (scan_cnt_reg == CNT_W'(NUM_TIMERS)) begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE: begin
                if (best_found_reg) begin
                    // A previous fire is now known not to be the last one.
                    if (!pend_valid_reg || out_free) begin
                        if (pend_valid_reg) begin
                            push_en        = 1'b1;
                            push_item.last = 1'b0;
                        end
                        ram_wr_en = 1'b1;
                        if (fire_removes) begin
                            valid_next[best_idx_reg] = 1'b0;
                        end
                        pend_item_next.kind         = KIND_FIRED;
                        pend_item_next.timer_id_res = best_entry_reg.id;
                        pend_item_next.repeats_left = fire_entry.repeats;
                        pend_item_next.last         = 1'b0;
                        pend_valid_next = 1'b1;
                        fire_cnt_next   = fire_cnt_reg + FIRE_CNT_W'(1);
                        scan_cnt_next   = '0;
                        best_found_next = 1'b0;
                        if (fire_cnt_reg == FIRE_CNT_W'(FIRE_LIMIT - 1)) begin
                            state_next = ST_FLUSH;
                        end else begin
                            state_next = ST_SCAN;
                        end
                    end
                end else if (pend_valid_reg) begin
                    state_next = ST_FLUSH;
                end else begin
                    state_next = ST_IDLE;
                end
            end

            ST_FLUSH: begin
                if (out_free) begin
                    push_en         = 1'b1;
                    push_item.last  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register.
    always_comb begin
        m_item_next = m_item_reg;
        if (push_en) begin
            m_valid_next = 1'b1;
            m_item_next  = push_item;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            time_reg       <= '0;
            valid_reg      <= '0;
            scan_cnt_reg   <= '0;
            eval_en_reg    <= 1'b0;
            best_found_reg <= 1'b0;
            fire_cnt_reg   <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            time_reg       <= time_next;
            valid_reg      <= valid_next;
            scan_cnt_reg   <= scan_cnt_next;
            eval_en_reg    <= eval_en_next;
            best_found_reg <= best_found_next;
            fire_cnt_reg   <= fire_cnt_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg         <= in_next;
        eval_idx_reg   <= eval_idx_next;
        best_idx_reg   <= best_idx_next;
        best_late_reg  <= best_late_next;
        best_entry_reg <= best_entry_next;
        pend_item_reg  <= pend_item_next;
        m_item_reg     <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

### rtl/core/pts_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module pts_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/pts_checker.sv
// Port-level assertions for the timer scheduler and the bind that attaches them.
`include "periodic_timer_scheduler_unit_defines.svh"

module pts_checker
    import pts_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);

    // A result that is not taken holds its value.
    `PTS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
                     m_valid && $stable(m_item), "result changed while stalled")

    // Only one input item is worked on at a time.
    `PTS_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready,
                     !s_ready, "input taken twice in a row")

    // Add answers are always the only result of their item.
    `PTS_ASSERT_IMPL(a_add_is_last, aclk, aresetn, m_valid && (m_item.kind != KIND_FIRED),
                     m_item.last, "add answer without last")

    // A rejected add reports no repeat count.
    `PTS_ASSERT_IMPL(a_reject_zero, aclk, aresetn, m_valid && (m_item.kind == KIND_REJECTED),
                     m_item.repeats_left == '0, "rejected add with repeat count")

endmodule

bind periodic_timer_scheduler_unit pts_checker u_pts_checker (.*);

### tb/periodic_timer_scheduler_unit_tb.sv
// Self-checking testbench for the periodic timer scheduler: directed and random items with a scheduler predictor.
module periodic_timer_scheduler_unit_tb;
    import pts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TW = TIME_WIDTH_DEF;
    localparam int SLOTS = NUM_TIMERS_DEF;
    // A tick costs about one table scan per fire plus one empty scan.
    localparam int SCAN_CYCLES = SLOTS + 3;
    localparam int DRAIN_CYCLES = 4 * SCAN_CYCLES;
    // The slowest stretch with no handshake is one or two scans plus
    // a sender gap or a receiver stall; this limit is many times that.
    localparam int STALL_LIMIT = 40 * SCAN_CYCLES;
    localparam int RANDOM_ITEMS = 330;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    periodic_timer_scheduler_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Items waiting to be driven, and results the predictor says must come back.
    in_item_t  pending_items[$];
    out_item_t awaited_results[$];
    int        error_count = 0;

    // The predictor's own copy of the timer table and the time counter.
    logic [TW-1:0]         now_ticks;
    logic                  slot_busy[SLOTS];
    logic [ID_W-1:0]       slot_tid[SLOTS];
    logic [TW-1:0]         slot_due[SLOTS];
    logic [INTERVAL_W-1:0] slot_period[SLOTS];
    logic [REPEAT_W-1:0]   slot_left[SLOTS];

    // Applies one accepted item to the predicted table and queues the
    // results it must cause, in order.
    function automatic void predict_schedule(input in_item_t it);
        int            i;
        int            free_slot;
        int            best;
        int            fires;
        logic [TW-1:0] late;
        logic [TW-1:0] best_late;
        out_item_t     res;

        res = '0;
        if (it.command == CMD_ADD) begin
            free_slot = -1;
            for (i = SLOTS - 1; i >= 0; i--) begin
                if (!slot_busy[i]) begin
                    free_slot = i;
                end
            end
            res.timer_id_res = it.timer_id;
            res.last = 1'b1;
            if (free_slot < 0) begin
                res.kind = KIND_REJECTED;
                res.repeats_left = '0;
            end else begin
                slot_busy[free_slot] = 1'b1;
                slot_tid[free_slot] = it.timer_id;
                slot_due[free_slot] = now_ticks + TW'(it.first_delay);
                // A zero period would never let the timer catch up, so it counts as one.
                slot_period[free_slot] = (it.interval == '0) ? INTERVAL_W'(1) : it.interval;
                slot_left[free_slot] = it.repeat_count;
                res.kind = KIND_ADDED;
                res.repeats_left = it.repeat_count;
            end
            awaited_results.push_back(res);
        end else begin
            now_ticks = now_ticks + 1'b1;
            fires = 0;
            // Fire the most overdue timer, lowest slot on ties, until nothing
            // is due or the per-tick fire budget is spent.
            while (fires < FIRE_LIMIT) begin
                best = -1;
                best_late = '0;
                for (i = 0; i < SLOTS; i++) begin
                    late = now_ticks - slot_due[i];
                    if (slot_busy[i] && !late[TW-1] && (best < 0 || late > best_late)) begin
                        best = i;
                        best_late = late;
                    end
                end
                if (best < 0) begin
                    break;
                end
                slot_due[best] = slot_due[best] + TW'(slot_period[best]);
                res.kind = KIND_FIRED;
                res.timer_id_res = slot_tid[best];
                res.repeats_left = '0;
                res.last = 1'b0;
                if (slot_left[best] != '0) begin
                    slot_left[best] = slot_left[best] - 1'b1;
                    res.repeats_left = slot_left[best];
                    if (slot_left[best] == '0) begin
                        slot_busy[best] = 1'b0;
                    end
                end
                awaited_results.push_back(res);
                fires++;
            end
            if (fires > 0) begin
                awaited_results[awaited_results.size() - 1].last = 1'b1;
            end
        end
    endfunction

    function automatic void queue_add(input logic [ID_W-1:0] id,
                                      input logic [DELAY_W-1:0] delay,
                                      input logic [INTERVAL_W-1:0] period,
                                      input logic [REPEAT_W-1:0] reps);
        in_item_t it;

        it = '0;
        it.command = CMD_ADD;
        it.timer_id = id;
        it.first_delay = delay;
        it.interval = period;
        it.repeat_count = reps;
        pending_items.push_back(it);
    endfunction

    function automatic void queue_tick();
        in_item_t it;

        // Only the command matters for a tick; the other fields carry noise.
        it.command = CMD_TICK;
        it.timer_id = ID_W'($urandom());
        it.first_delay = DELAY_W'($urandom());
        it.interval = INTERVAL_W'($urandom());
        it.repeat_count = REPEAT_W'($urandom());
        pending_items.push_back(it);
    endfunction

    // Driver: presents items from the pending queue, holding each one until
    // it is taken, then idles for a drawn number of cycles. In calm stretches
    // items go back to back.
    int send_gap = 0;
    logic send_calm = 1'b0;

    always @(posedge aclk) begin
        int gap;

        if (!aresetn) begin
            s_valid <= 1'b0;
            s_item <= '0;
            send_gap <= 0;
            send_calm <= 1'b0;
        end else if (!(s_valid && !s_ready)) begin
            gap = send_gap;
            if (s_valid) begin
                // The item was taken at this edge.
                predict_schedule(s_item);
                gap = send_calm ? 0 : $urandom_range(0, 10);
                if ($urandom_range(0, 19) == 0) begin
                    send_calm <= !send_calm;
                end
            end
            if (gap == 0 && pending_items.size() != 0) begin
                s_item <= pending_items.pop_front();
                s_valid <= 1'b1;
                send_gap <= 0;
            end else begin
                s_valid <= 1'b0;
                send_gap <= (gap > 0) ? gap - 1 : 0;
            end
        end
    end

    // Monitor: checks each result against the oldest awaited one, then
    // lowers ready for a drawn number of cycles before the next result.
    int recv_gap = 0;
    logic recv_calm = 1'b0;

    always @(posedge aclk) begin
        int gap_next;
        out_item_t want;

        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_gap <= 0;
            recv_calm <= 1'b0;
        end else begin
            gap_next = recv_gap;
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: result with nothing awaited: kind %0d id %0d left %0d last %0d",
                             $time, m_item.kind, m_item.timer_id_res, m_item.repeats_left,
                             m_item.last);
                    error_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (m_item.kind !== want.kind) begin
                        $display("%0t: kind mismatch, expected %0d, actual %0d",
                                 $time, want.kind, m_item.kind);
                        error_count++;
                    end
                    if (m_item.timer_id_res !== want.timer_id_res) begin
                        $display("%0t: timer id mismatch, expected %0d, actual %0d",
                                 $time, want.timer_id_res, m_item.timer_id_res);
                        error_count++;
                    end
                    if (m_item.repeats_left !== want.repeats_left) begin
                        $display("%0t: repeats left mismatch, expected %0d, actual %0d",
                                 $time, want.repeats_left, m_item.repeats_left);
                        error_count++;
                    end
                    if (m_item.last !== want.last) begin
                        $display("%0t: last flag mismatch, expected %0d, actual %0d",
                                 $time, want.last, m_item.last);
                        error_count++;
                    end
                end
                gap_next = recv_calm ? 0 : $urandom_range(0, 10);
                if ($urandom_range(0, 19) == 0) begin
                    recv_calm <= !recv_calm;
                end
            end else if (gap_next > 0) begin
                gap_next--;
            end
            recv_gap <= gap_next;
            m_ready <= (gap_next == 0);
        end
    end

    // Watchdog: a long run of cycles with no handshake on either side means
    // the block has hung or lost a result.
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        int n;
        int roll;
        int forever_budget;
        int far_budget;
        in_item_t it;

        now_ticks = '0;
        for (n = 0; n < SLOTS; n++) begin
            slot_busy[n] = 1'b0;
            slot_tid[n] = '0;
            slot_due[n] = '0;
            slot_period[n] = '0;
            slot_left[n] = '0;
        end

        // Directed part. A tick on an empty table gives no result.
        queue_tick();
        // A zero period is taken as one, so this timer catches up and
        // fires twice on the first tick, then frees its slot.
        queue_add(8'h00, '0, '0, 16'd2);
        queue_tick();
        // All-ones fields: the first deadline is as far ahead as it can be,
        // and the repeat count is the largest, so this slot stays taken.
        queue_add(8'hFF, {DELAY_W{1'b1}}, {INTERVAL_W{1'b1}}, {REPEAT_W{1'b1}});
        // A timer that repeats forever, every third tick.
        queue_add(8'h5A, 31'd1, 31'd3, 16'd0);
        // Fill the table with timers that are due at once and catch up, so
        // the next tick hits the fire budget; one more add finds it full.
        for (n = 0; n < SLOTS - 2; n++) begin
            queue_add(ID_W'(8'h10 + n), '0, 31'd1, 16'd3);
        end
        queue_add(8'hA5, 31'h2AAA_AAAA, 31'h5555_5555, 16'hAAAA);
        queue_tick();
        queue_tick();
        queue_tick();

        // Random part: mostly short-lived timers with small delays so that
        // fires, catch-ups, frees and a full table all keep recurring. Timers
        // that never leave are rationed so the table does not clog for good.
        forever_budget = 2;
        far_budget = 3;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 35) begin
                it = '0;
                it.command = CMD_ADD;
                it.timer_id = ID_W'($urandom());
                it.first_delay = DELAY_W'($urandom_range(0, 12));
                it.interval = INTERVAL_W'($urandom_range(0, 8));
                it.repeat_count = REPEAT_W'($urandom_range(1, 6));
                roll = $urandom_range(0, 99);
                if (roll < 3 && forever_budget > 0) begin
                    it.repeat_count = '0;
                    it.interval = INTERVAL_W'($urandom_range(2, 20));
                    forever_budget--;
                end else if (roll < 6 && far_budget > 0) begin
                    it.first_delay = DELAY_W'($urandom());
                    far_budget--;
                end else if (roll < 14) begin
                    // One fire only, so a huge period leaves nothing behind.
                    it.interval = INTERVAL_W'($urandom());
                    it.repeat_count = 16'd1;
                end
                pending_items.push_back(it);
            end else begin
                queue_tick();
            end
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait until every item has been taken and every result has come back.
        while (pending_items.size() != 0 || s_valid || awaited_results.size() != 0) begin
            @(posedge aclk);
        end
        // The last tick may still be scanning; give it time to show any stray result.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
